FILE: hdl/chip8_instruction_executor_top_macros.svh
// assertion macros for the chip8 executor
`ifndef CHIP8_INSTRUCTION_EXECUTOR_TOP_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_TOP_MACROS_SVH

// same-cycle implication
`define C8X_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define C8X_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/c8x_pkg.sv
`default_nettype none
package c8x_pkg;

  localparam int MEM_DEPTH   = 4096;
  localparam int STACK_DEPTH = 16;
  localparam int SCREEN_COLS = 64;
  localparam int SCREEN_ROWS = 32;
  localparam int NUM_V       = 16;
  localparam int FONT_LEN    = 80;

  localparam int MEM_AW     = $clog2(MEM_DEPTH);
  localparam int SIDX_W     = $clog2(STACK_DEPTH);
  localparam int SP_W       = $clog2(STACK_DEPTH + 1);
  localparam int ROW_W      = $clog2(SCREEN_ROWS);
  localparam int COL_W      = $clog2(SCREEN_COLS);
  localparam int V_AW       = $clog2(NUM_V);
  localparam int CNT_W      = MEM_AW;
  localparam int WRAP_STEPS = (4096 + 15) / MEM_DEPTH;
  localparam int STATE_W    = 5;

  localparam logic [11:0] PC_RESET = 12'd512;

  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_EXEC   = 3'd1;
  localparam logic [2:0] OP_RDMEM  = 3'd2;
  localparam logic [2:0] OP_RDROW  = 3'd3;
  localparam logic [2:0] OP_RDREG  = 3'd4;

  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SE   = 4'h3;
  localparam logic [3:0] GRP_SNE  = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LD   = 4'h6;
  localparam logic [3:0] GRP_ADD  = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_LDI  = 4'hA;
  localparam logic [3:0] GRP_JPV  = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;
  localparam logic [3:0] GRP_KEY  = 4'hE;
  localparam logic [3:0] GRP_MISC = 4'hF;

  localparam logic [15:0] OPC_CLS = 16'h00E0;
  localparam logic [15:0] OPC_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [7:0] KK_SKP   = 8'h9E;
  localparam logic [7:0] KK_SKNP  = 8'hA1;
  localparam logic [7:0] KK_LDDT  = 8'h07;
  localparam logic [7:0] KK_WAITK = 8'h0A;
  localparam logic [7:0] KK_STDT  = 8'h15;
  localparam logic [7:0] KK_STST  = 8'h18;
  localparam logic [7:0] KK_ADDI  = 8'h1E;
  localparam logic [7:0] KK_FONT  = 8'h29;
  localparam logic [7:0] KK_BCD   = 8'h33;
  localparam logic [7:0] KK_STORE = 8'h55;
  localparam logic [7:0] KK_LOAD  = 8'h65;

  localparam logic [STATE_W-1:0] S_CLR  = 5'd0;
  localparam logic [STATE_W-1:0] S_IDLE = 5'd1;
  localparam logic [STATE_W-1:0] S_ACC  = 5'd2;
  localparam logic [STATE_W-1:0] S_RD   = 5'd3;
  localparam logic [STATE_W-1:0] S_F1   = 5'd4;
  localparam logic [STATE_W-1:0] S_F2   = 5'd5;
  localparam logic [STATE_W-1:0] S_F3   = 5'd6;
  localparam logic [STATE_W-1:0] S_F4   = 5'd7;
  localparam logic [STATE_W-1:0] S_EX   = 5'd8;
  localparam logic [STATE_W-1:0] S_VF   = 5'd9;
  localparam logic [STATE_W-1:0] S_CLS  = 5'd10;
  localparam logic [STATE_W-1:0] S_D0   = 5'd11;
  localparam logic [STATE_W-1:0] S_D1   = 5'd12;
  localparam logic [STATE_W-1:0] S_D2   = 5'd13;
  localparam logic [STATE_W-1:0] S_BCD  = 5'd14;
  localparam logic [STATE_W-1:0] S_ST0  = 5'd15;
  localparam logic [STATE_W-1:0] S_ST1  = 5'd16;
  localparam logic [STATE_W-1:0] S_LD0  = 5'd17;
  localparam logic [STATE_W-1:0] S_LD1  = 5'd18;
  localparam logic [STATE_W-1:0] S_DONE = 5'd19;

  typedef struct packed {
    logic [2:0]  op;
    logic [11:0] address;
    logic [7:0]  data;
    logic [7:0]  random_byte;
    logic [15:0] keys;
  } in_item_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic [11:0] pc_value;
    logic [11:0] index_value;
    logic        screen_changed;
    logic [7:0]  delay_value;
    logic [7:0]  sound_value;
    logic        unknown_opcode;
  } out_item_t;

  typedef struct packed {
    logic               accept;
    logic [STATE_W-1:0] state;
    logic [CNT_W-1:0]   cnt;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] opc;
  } stat_t;

  localparam logic [7:0] FONT [FONT_LEN] = '{
    8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
    8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
    8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
    8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
    8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
    8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
    8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
    8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80
  };

  function automatic logic [MEM_AW-1:0] mem_wrap(input logic [12:0] a);
    logic [12:0] t;
    t = a;
    for (int k = 0; k < WRAP_STEPS; k++) begin
      if (t >= 13'(MEM_DEPTH)) begin
        t = t - 13'(MEM_DEPTH);
      end
    end
    return t[MEM_AW-1:0];
  endfunction

  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [1:0]  hund;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [3:0]  ones;
    if (v >= 8'd200) begin
      hund = 2'd2;
      rem  = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      hund = 2'd1;
      rem  = 7'(v - 8'd100);
    end else begin
      hund = 2'd0;
      rem  = v[6:0];
    end
    prod = 15'(rem) * 15'd205;
    tens = prod[14:11];
    ones = 4'(rem - 7'(tens) * 7'd10);
    if (sel == 2'd0) begin
      return {6'd0, hund};
    end else if (sel == 2'd1) begin
      return {4'd0, tens};
    end
    return {4'd0, ones};
  endfunction

endpackage
`default_nettype wire

FILE: hdl/c8x_ram.sv
`default_nettype none
module c8x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/c8x_ctrl.sv
`default_nettype none
module c8x_ctrl
  import c8x_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire stat_t st,
  output cmd_t       cmd,
  output logic       busy
);

  logic [STATE_W-1:0] state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [3:0]         grp, x, n;
  logic [7:0]         kk;

  assign grp = st.opc[15:12];
  assign x   = st.opc[11:8];
  assign n   = st.opc[3:0];
  assign kk  = st.opc[7:0];

  assign busy       = (state_r != S_IDLE);
  assign cmd.accept = (state_r == S_IDLE) && start;
  assign cmd.state  = state_r;
  assign cmd.cnt    = cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_CLR: begin
        if (cnt_r == CNT_W'(MEM_DEPTH - 1)) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_ACC;
          cnt_nxt   = '0;
        end
      end
      S_ACC: begin
        if (st.op == OP_EXEC) begin
          state_nxt = S_F1;
        end else if (st.op == OP_RDMEM || st.op == OP_RDROW || st.op == OP_RDREG) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RD: state_nxt = S_DONE;
      S_F1: state_nxt = S_F2;
      S_F2: state_nxt = S_F3;
      S_F3: state_nxt = S_F4;
      S_F4: state_nxt = S_EX;
      S_EX: begin
        cnt_nxt = '0;
        priority if (st.opc == OPC_CLS) begin
          state_nxt = S_CLS;
        end else if (grp == GRP_DRW) begin
          state_nxt = (n == 4'd0) ? S_VF : S_D0;
        end else if (grp == GRP_ALU && (n == ALU_ADD || n == ALU_SUB || n == ALU_SHR ||
                                        n == ALU_SUBN || n == ALU_SHL)) begin
          state_nxt = S_VF;
        end else if (grp == GRP_MISC && kk == KK_BCD) begin
          state_nxt = S_BCD;
        end else if (grp == GRP_MISC && kk == KK_STORE) begin
          state_nxt = S_ST0;
        end else if (grp == GRP_MISC && kk == KK_LOAD) begin
          state_nxt = S_LD0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_VF: state_nxt = S_DONE;
      S_CLS: begin
        if (cnt_r == CNT_W'(SCREEN_ROWS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_D0: state_nxt = S_D1;
      S_D1: state_nxt = S_D2;
      S_D2: begin
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = (cnt_r[3:0] + 4'd1 == n) ? S_VF : S_D0;
      end
      S_BCD: begin
        if (cnt_r[1:0] == 2'd2) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ST0: state_nxt = S_ST1;
      S_ST1: begin
        if (cnt_r[3:0] == x) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ST0;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      S_LD0: state_nxt = S_LD1;
      S_LD1: begin
        if (cnt_r[3:0] == x) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_LD0;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/c8x_dpath.sv
`default_nettype none
module c8x_dpath
  import c8x_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire in_item_t    in_item,
  input  wire cmd_t        cmd,
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_data,
  output stat_t            st,
  output out_item_t        out_item,
  output logic             out_strobe
);

  // architectural registers
  logic [11:0]     pc_r, pc_nxt;
  logic [11:0]     i_r, i_nxt;
  logic [SP_W-1:0] sp_r, sp_nxt;
  logic [7:0]      dt_r, dt_nxt;
  logic [7:0]      st_r, st_nxt;
  logic [11:0]     stack_r [STACK_DEPTH];
  logic            stack_we;

  // per-item working registers
  in_item_t        item_r, item_nxt;
  logic [15:0]     opc_r, opc_nxt;
  logic [7:0]      vx_r, vx_nxt, vy_r, vy_nxt, sprite_r, sprite_nxt;
  logic            flag_r, flag_nxt, drew_r, drew_nxt, unk_r, unk_nxt;
  logic [63:0]     rd_r, rd_nxt;
  out_item_t       out_r;
  logic            strobe_r;

  // memory ports
  logic              m_we;
  logic [MEM_AW-1:0] m_waddr, m_raddr;
  logic [7:0]        m_wdata, m_rdata;
  logic              v_we;
  logic [V_AW-1:0]   v_waddr, v_raddr;
  logic [7:0]        v_wdata, v_rdata;
  logic              f_we;
  logic [ROW_W-1:0]  f_waddr, f_raddr;
  logic [SCREEN_COLS-1:0] f_wdata, f_rdata;

  logic [3:0]  grp, x, y, n;
  logic [7:0]  kk;
  logic [11:0] nnn, pc2, pc4;
  logic [8:0]  sum9;
  logic [SCREEN_COLS-1:0]   spr_wide, mask;
  logic [2*SCREEN_COLS-1:0] rot;
  logic [ROW_W-1:0]         draw_row;

  c8x_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata)
  );

  c8x_ram #(.WIDTH(8), .DEPTH(NUM_V)) u_vreg (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr(v_raddr), .rdata(v_rdata)
  );

  c8x_ram #(.WIDTH(SCREEN_COLS), .DEPTH(SCREEN_ROWS)) u_fb (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata)
  );

  assign grp  = opc_r[15:12];
  assign x    = opc_r[11:8];
  assign y    = opc_r[7:4];
  assign n    = opc_r[3:0];
  assign kk   = opc_r[7:0];
  assign nnn  = opc_r[11:0];
  assign pc2  = pc_r + 12'd2;
  assign pc4  = pc_r + 12'd4;
  assign sum9 = {1'b0, vx_r} + {1'b0, vy_r};

  // sprite row placed at column vx with wrap
  assign spr_wide = {sprite_r, {(SCREEN_COLS-8){1'b0}}};
  assign rot      = {spr_wide, spr_wide} >> vx_r[COL_W-1:0];
  assign mask     = rot[SCREEN_COLS-1:0];
  assign draw_row = ROW_W'(vy_r + 8'(cmd.cnt[3:0]));

  assign st.op  = item_r.op;
  assign st.opc = opc_r;

  always_comb begin
    pc_nxt     = pc_r;
    i_nxt      = i_r;
    sp_nxt     = sp_r;
    dt_nxt     = dt_r;
    st_nxt     = st_r;
    stack_we   = 1'b0;
    item_nxt   = item_r;
    opc_nxt    = opc_r;
    vx_nxt     = vx_r;
    vy_nxt     = vy_r;
    sprite_nxt = sprite_r;
    flag_nxt   = flag_r;
    drew_nxt   = drew_r;
    unk_nxt    = unk_r;
    rd_nxt     = rd_r;
    m_we       = 1'b0;
    m_waddr    = '0;
    m_wdata    = '0;
    m_raddr    = '0;
    v_we       = 1'b0;
    v_waddr    = '0;
    v_wdata    = '0;
    v_raddr    = '0;
    f_we       = 1'b0;
    f_waddr    = '0;
    f_wdata    = '0;
    f_raddr    = '0;

    if (cmd.accept) begin
      item_nxt = in_item;
    end

    unique case (cmd.state)
      S_CLR: begin
        m_we    = 1'b1;
        m_waddr = cmd.cnt;
        m_wdata = (cmd.cnt < CNT_W'(FONT_LEN)) ? FONT[7'(cmd.cnt)] : 8'd0;
        if (cmd.cnt < CNT_W'(SCREEN_ROWS)) begin
          f_we    = 1'b1;
          f_waddr = cmd.cnt[ROW_W-1:0];
        end
        if (cmd.cnt < CNT_W'(NUM_V)) begin
          v_we    = 1'b1;
          v_waddr = cmd.cnt[V_AW-1:0];
        end
      end
      S_ACC: begin
        rd_nxt   = '0;
        drew_nxt = 1'b0;
        unk_nxt  = 1'b0;
        unique case (item_r.op)
          OP_WRITE: begin
            if (13'(item_r.address) < 13'(MEM_DEPTH)) begin
              m_we    = 1'b1;
              m_waddr = item_r.address[MEM_AW-1:0];
              m_wdata = item_r.data;
            end
          end
          OP_EXEC:  m_raddr = mem_wrap(13'(pc_r));
          OP_RDMEM: m_raddr = item_r.address[MEM_AW-1:0];
          OP_RDROW: f_raddr = item_r.address[ROW_W-1:0];
          OP_RDREG: v_raddr = item_r.address[V_AW-1:0];
          default: ;
        endcase
      end
      S_RD: begin
        unique case (item_r.op)
          OP_RDMEM:
            rd_nxt = (13'(item_r.address) < 13'(MEM_DEPTH)) ? {56'd0, m_rdata} : 64'd0;
          OP_RDROW:
            rd_nxt = (item_r.address < 12'(SCREEN_ROWS)) ? 64'(f_rdata) : 64'd0;
          OP_RDREG:
            rd_nxt = (item_r.address < 12'(NUM_V)) ? {56'd0, v_rdata} : 64'd0;
          default: rd_nxt = '0;
        endcase
      end
      S_F1: begin
        opc_nxt[15:8] = m_rdata;
        m_raddr       = mem_wrap(13'(pc_r) + 13'd1);
      end
      S_F2: begin
        opc_nxt[7:0] = m_rdata;
        v_raddr      = x;
      end
      S_F3: begin
        vx_nxt  = v_rdata;
        v_raddr = (grp == GRP_JPV) ? 4'd0 : y;
      end
      S_F4: vy_nxt = v_rdata;
      S_EX: begin
        pc_nxt = pc2;
        unique case (grp)
          GRP_SYS: begin
            if (opc_r == OPC_CLS) begin
              drew_nxt = 1'b1;
            end else if (opc_r == OPC_RET && sp_r != '0) begin
              sp_nxt = sp_r - 1'b1;
              pc_nxt = stack_r[SIDX_W'(sp_r - 1'b1)];
            end
          end
          GRP_JP: pc_nxt = nnn;
          GRP_CALL: begin
            if (sp_r < SP_W'(STACK_DEPTH)) begin
              stack_we = 1'b1;
              sp_nxt   = sp_r + 1'b1;
            end
            pc_nxt = nnn;
          end
          GRP_SE:  if (vx_r == kk) pc_nxt = pc4;
          GRP_SNE: if (vx_r != kk) pc_nxt = pc4;
          GRP_SER: begin
            if (n != 4'd0) unk_nxt = 1'b1;
            else if (vx_r == vy_r) pc_nxt = pc4;
          end
          GRP_LD: begin
            v_we = 1'b1; v_waddr = x; v_wdata = kk;
          end
          GRP_ADD: begin
            v_we = 1'b1; v_waddr = x; v_wdata = vx_r + kk;
          end
          GRP_ALU: begin
            v_we    = 1'b1;
            v_waddr = x;
            unique case (n)
              ALU_MOV: v_wdata = vy_r;
              ALU_OR:  v_wdata = vx_r | vy_r;
              ALU_AND: v_wdata = vx_r & vy_r;
              ALU_XOR: v_wdata = vx_r ^ vy_r;
              ALU_ADD: begin
                v_wdata  = sum9[7:0];
                flag_nxt = sum9[8];
              end
              ALU_SUB: begin
                v_wdata  = vx_r - vy_r;
                flag_nxt = (vx_r > vy_r);
              end
              ALU_SHR: begin
                v_wdata  = {1'b0, vx_r[7:1]};
                flag_nxt = vx_r[0];
              end
              ALU_SUBN: begin
                v_wdata  = vy_r - vx_r;
                flag_nxt = (vy_r > vx_r);
              end
              ALU_SHL: begin
                v_wdata  = {vx_r[6:0], 1'b0};
                flag_nxt = vx_r[7];
              end
              default: begin
                v_we    = 1'b0;
                unk_nxt = 1'b1;
              end
            endcase
          end
          GRP_SNER: begin
            if (n != 4'd0) unk_nxt = 1'b1;
            else if (vx_r != vy_r) pc_nxt = pc4;
          end
          GRP_LDI: i_nxt = nnn;
          GRP_JPV: pc_nxt = nnn + {4'd0, vy_r};
          GRP_RND: begin
            v_we = 1'b1; v_waddr = x; v_wdata = item_r.random_byte & kk;
          end
          GRP_DRW: begin
            flag_nxt = 1'b0;
            drew_nxt = 1'b1;
          end
          GRP_KEY: begin
            if (kk == KK_SKP) begin
              if (item_r.keys[vx_r[3:0]]) pc_nxt = pc4;
            end else if (kk == KK_SKNP) begin
              if (!item_r.keys[vx_r[3:0]]) pc_nxt = pc4;
            end else begin
              unk_nxt = 1'b1;
            end
          end
          GRP_MISC: begin
            unique case (kk)
              KK_LDDT: begin
                v_we = 1'b1; v_waddr = x; v_wdata = dt_r;
              end
              KK_WAITK: ;
              KK_STDT:  dt_nxt = vx_r;
              KK_STST:  st_nxt = vx_r;
              KK_ADDI:  i_nxt = i_r + {4'd0, vx_r};
              KK_FONT:  i_nxt = {6'd0, vx_r[3:0], 2'd0} + {8'd0, vx_r[3:0]};
              KK_BCD, KK_STORE, KK_LOAD: ;
              default:  unk_nxt = 1'b1;
            endcase
          end
          default: ;
        endcase
      end
      S_VF: begin
        v_we    = 1'b1;
        v_waddr = 4'hF;
        v_wdata = {7'd0, flag_r};
      end
      S_CLS: begin
        f_we    = 1'b1;
        f_waddr = cmd.cnt[ROW_W-1:0];
      end
      S_D0: m_raddr = mem_wrap(13'(i_r) + 13'(cmd.cnt[3:0]));
      S_D1: begin
        sprite_nxt = m_rdata;
        f_raddr    = draw_row;
      end
      S_D2: begin
        f_we     = 1'b1;
        f_waddr  = draw_row;
        f_wdata  = f_rdata ^ mask;
        flag_nxt = flag_r | (|(f_rdata & mask));
      end
      S_BCD: begin
        m_we    = 1'b1;
        m_waddr = mem_wrap(13'(i_r) + 13'(cmd.cnt[1:0]));
        m_wdata = bcd_digit(vx_r, cmd.cnt[1:0]);
      end
      S_ST0: v_raddr = cmd.cnt[3:0];
      S_ST1: begin
        m_we    = 1'b1;
        m_waddr = mem_wrap(13'(i_r) + 13'(cmd.cnt[3:0]));
        m_wdata = v_rdata;
      end
      S_LD0: m_raddr = mem_wrap(13'(i_r) + 13'(cmd.cnt[3:0]));
      S_LD1: begin
        v_we    = 1'b1;
        v_waddr = cmd.cnt[3:0];
        v_wdata = m_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= PC_RESET;
      i_r      <= '0;
      sp_r     <= '0;
      dt_r     <= '0;
      st_r     <= '0;
      strobe_r <= 1'b0;
    end else begin
      pc_r     <= cfg_we ? cfg_data : pc_nxt;
      i_r      <= i_nxt;
      sp_r     <= sp_nxt;
      dt_r     <= dt_nxt;
      st_r     <= st_nxt;
      strobe_r <= (cmd.state == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    opc_r    <= opc_nxt;
    vx_r     <= vx_nxt;
    vy_r     <= vy_nxt;
    sprite_r <= sprite_nxt;
    flag_r   <= flag_nxt;
    drew_r   <= drew_nxt;
    unk_r    <= unk_nxt;
    rd_r     <= rd_nxt;
    if (stack_we) begin
      stack_r[sp_r[SIDX_W-1:0]] <= pc2;
    end
    if (cmd.state == S_DONE) begin
      out_r.read_data      <= rd_r;
      out_r.pc_value       <= pc_r;
      out_r.index_value    <= i_r;
      out_r.screen_changed <= drew_r;
      out_r.delay_value    <= dt_r;
      out_r.sound_value    <= st_r;
      out_r.unknown_opcode <= unk_r;
    end
  end

  assign out_item   = out_r;
  assign out_strobe = strobe_r;

endmodule
`default_nettype wire

FILE: hdl/chip8_instruction_executor_top.sv
// memory, register and display-row reads: ACC, RD and DONE; out_strobe follows DONE
// execute: F1 to F4, EX, DONE for most; draw adds D0, D1, D2 per sprite row, then VF;
// 00E0 CLS per row, Fx33 BCD per digit, Fx55 ST0/ST1 and Fx65 LD0/LD1 per register
// one item at a time; a new item is taken in the cycle its result is strobed
// after reset a clearing pass over all memory addresses loads the font and clears memory,
// display and V registers; busy stays high until it ends; results cannot be stalled
`default_nettype none
module chip8_instruction_executor_top
  import c8x_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item,
  output logic             out_strobe,
  output out_item_t        out_item,
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_data
);

`include "chip8_instruction_executor_top_macros.svh"

  cmd_t  cmd;
  stat_t st;

  c8x_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .st(st), .cmd(cmd), .busy(busy)
  );

  c8x_dpath u_dpath (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .st(st), .out_item(out_item), .out_strobe(out_strobe)
  );

  // a beat taken always starts work
  `C8X_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not start work")
  // each result is a single-cycle strobe
  `C8X_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "result strobe held two cycles")
  // result shows only once the block is free again
  `C8X_ASSERT_NOW(a_strobe_idle, out_strobe, !busy, "result strobed while busy")

endmodule
`default_nettype wire
